// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/isort_pkg.sv =====
package isort_pkg;

	localparam int unsigned ValueWidth = 32;

	typedef logic signed [ValueWidth-1:0] value_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/isort_in_if.sv =====
interface isort_in_if
	import isort_pkg::*;
;
	logic   valid;
	logic   ready;
	value_t sample;
	logic   final_in;

	modport source (output valid, output sample, output final_in, input ready);
	modport sink (input valid, input sample, input final_in, output ready);
endinterface

// ===== hw/rtl/isort_out_if.sv =====
interface isort_out_if
	import isort_pkg::*;
;
	logic   valid;
	logic   ready;
	value_t sorted_value;
	logic   final_out;
	logic   overflow;

	modport source (output valid, output sorted_value, output final_out, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_out, input overflow,
		output ready);
endinterface

// ===== hw/rtl/isort_cell.sv =====
module isort_cell
	import isort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  value_t     v,
	input  value_t     prev_val,
	input  logic       prev_gt,
	input  logic       prev_occ,
	input  value_t     next_val,
	input  logic       next_occ,
	output value_t     val,
	output logic       occ,
	output logic       gt
);
	value_t val_q;
	logic   occ_q;

	assign val = val_q;
	assign occ = occ_q;
	assign gt  = occ_q && (val_q > v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.shift) begin
			occ_q <= next_occ;
		end else if (ctrl.ins) begin
			occ_q <= occ_q | prev_occ;
		end
	end

	// larger entries go up one, new value at boundary; shift moves down
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || !occ_q) begin
				val_q <= v;
			end
		end
	end
endmodule

// ===== hw/rtl/insertion_sorter.sv =====
// insertion_sorter: streaming sort of signed 32-bit values in a row of MAX_COUNT cells.
// items channel: one sample per transaction; final_in on the last sample closes the set.
// results channel: the held values in ascending order, final_out on the largest,
// overflow on every result if samples of the set were dropped for lack of room.
// an input transaction is taken every cycle while a set is being collected: each
// cell compares the sample with its own entry and hands a larger entry to its upper
// neighbor, all cells at once, so insertion does not depend on the fill.
// after the closing transaction drain_q is set and the output register then takes
// the first result; the cells shift down one entry per cycle into the output
// register while the receiver keeps ready high.
// no sample is taken while a set drains: items.ready stays low until the last result
// of the set is in the output register, so sets are collected and drained in turn.
// when results.ready is low while a result is waiting, the output register holds it
// and the cells hold still; nothing is lost.
// arst_n empties all cells and clears the dropped flag; the block is ready at once.
// equal values leave in their arrival order.
`include "assert_macros.svh"

module insertion_sorter
	import isort_pkg::*;
#(
	parameter int unsigned MAX_COUNT = 16
) (
	input logic          clk,
	input logic          arst_n,
	isort_in_if.sink     items,
	isort_out_if.source  results
);
	value_t               val_w [MAX_COUNT];
	logic [MAX_COUNT-1:0] occ_w;
	logic [MAX_COUNT-1:0] gt_w;
	cell_ctrl_t           ctrl;

	logic   drain_q;
	logic   drop_q;
	logic   out_valid_q;
	value_t out_value_q;
	logic   out_final_q;
	logic   out_ovf_q;

	logic accept;
	logic full;
	logic emit;
	logic emit_last;

	assign full      = occ_w[MAX_COUNT-1];
	assign accept    = items.valid && items.ready;
	assign emit      = drain_q && occ_w[0] && (!out_valid_q || results.ready);
	assign emit_last = !occ_w[1];

	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = emit;

	assign items.ready          = !drain_q;
	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.final_out    = out_final_q;
	assign results.overflow     = out_ovf_q;

	for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
		value_t prev_val;
		logic   prev_gt;
		logic   prev_occ;
		value_t next_val;
		logic   next_occ;

		if (i == 0) begin : g_first
			assign prev_val = '0;
			assign prev_gt  = 1'b0;
			assign prev_occ = 1'b1;
		end else begin : g_mid
			assign prev_val = val_w[i-1];
			assign prev_gt  = gt_w[i-1];
			assign prev_occ = occ_w[i-1];
		end

		if (i == MAX_COUNT - 1) begin : g_last
			assign next_val = '0;
			assign next_occ = 1'b0;
		end else begin : g_up
			assign next_val = val_w[i+1];
			assign next_occ = occ_w[i+1];
		end

		isort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.v        (items.sample),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.prev_occ (prev_occ),
			.next_val (next_val),
			.next_occ (next_occ),
			.val      (val_w[i]),
			.occ      (occ_w[i]),
			.gt       (gt_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (full) begin
					drop_q <= 1'b1;
				end
				if (items.final_in) begin
					drain_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (emit_last) begin
					drain_q <= 1'b0;
					drop_q  <= 1'b0;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= val_w[0];
			out_final_q <= emit_last;
			out_ovf_q   <= drop_q;
		end
	end

	// occupied cells form an unbroken run from cell 0
	`ASSERT_IMPLY(a_occ_prefix, 1'b1, ((occ_w + MAX_COUNT'(1)) & occ_w) == '0,
		"occupied cells are not contiguous")
	`ASSERT_IMPLY(a_drain_nonempty, drain_q, occ_w[0], "draining with an empty row")
	`ASSERT_NEXT(a_last_ends_drain, emit && emit_last, !drain_q && !occ_w[0],
		"set still held after its last result")

	for (genvar i = 0; i < MAX_COUNT - 1; i++) begin : g_chk
		`ASSERT_IMPLY(a_sorted, occ_w[i] && occ_w[i+1], !(val_w[i] > val_w[i+1]),
			"cell entries out of order")
	end
endmodule

// ===== bench/insertion_sorter_tb.sv =====
`timescale 1ns / 100ps

module insertion_sorter_tb
	import isort_pkg::*;
;

	localparam int unsigned MAX_COUNT = 16;
	localparam int unsigned ITEM_TARGET = 280;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct {
		value_t sample;
		logic   final_in;
	} sort_item_t;

	typedef struct {
		value_t sorted_value;
		logic   final_out;
		logic   overflow;
	} sorted_result_t;

	logic clk;
	logic arst_n;

	isort_in_if  items_if();
	isort_out_if results_if();

	insertion_sorter #(
		.MAX_COUNT(MAX_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	sort_item_t     pending_items[$];
	sorted_result_t expected_results[$];

	// predictor state
	value_t      held_values[MAX_COUNT];
	int unsigned held_count;
	logic        held_dropped;

	int unsigned error_count;
	int unsigned accepted_items;
	int unsigned stall_cycles;
	logic        item_taken;
	logic        calm;

	always #5 clk = ~clk;

	// no idling on either side for a stretch in the middle of the run
	assign calm = (accepted_items >= 120) && (accepted_items < 180);

	task automatic add_item(value_t v, logic f);
		sort_item_t it;
		it.sample = v;
		it.final_in = f;
		pending_items.push_back(it);
	endtask

	task automatic add_set(int unsigned len);
		value_t v;
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2, 3: v = $signed($urandom_range(7)) - 3;
				default: v = $urandom;
			endcase
			add_item(v, i == len - 1);
		end
	endtask

	task automatic sort_transaction(value_t v, logic last);
		sorted_result_t r;
		int unsigned pos;
		if (held_count < MAX_COUNT) begin
			pos = held_count;
			while (pos > 0 && held_values[pos - 1] > v) begin
				held_values[pos] = held_values[pos - 1];
				pos--;
			end
			held_values[pos] = v;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			for (int unsigned k = 0; k < held_count; k++) begin
				r.sorted_value = held_values[k];
				r.final_out = (k + 1 == held_count);
				r.overflow = held_dropped;
				expected_results.push_back(r);
			end
			held_count = 0;
			held_dropped = 1'b0;
		end
	endtask

	// driver
	always @(negedge clk) begin
		logic       nv;
		sort_item_t it;
		nv = 1'b0;
		it.sample = items_if.sample;
		it.final_in = items_if.final_in;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (items_if.valid && !item_taken) begin
			nv = 1'b1;
		end else if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
			it = pending_items.pop_front();
			nv = 1'b1;
		end
		items_if.valid <= nv;
		items_if.sample <= it.sample;
		items_if.final_in <= it.final_in;
		results_if.ready <= arst_n && (calm || $urandom_range(99) >= 30);
	end

	// monitor
	always @(posedge clk) begin
		sorted_result_t exp_r;
		logic in_acc;
		logic out_acc;
		in_acc = arst_n && items_if.valid && items_if.ready;
		out_acc = arst_n && results_if.valid && results_if.ready;
		item_taken <= in_acc;
		if (in_acc) begin
			accepted_items <= accepted_items + 1;
			sort_transaction(items_if.sample, items_if.final_in);
		end
		if (out_acc) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: sorted_value %0d",
					results_if.sorted_value);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (results_if.sorted_value !== exp_r.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						exp_r.sorted_value, results_if.sorted_value);
					error_count++;
				end
				if (results_if.final_out !== exp_r.final_out) begin
					$error("final_out: expected %0b, got %0b",
						exp_r.final_out, results_if.final_out);
					error_count++;
				end
				if (results_if.overflow !== exp_r.overflow) begin
					$error("overflow: expected %0b, got %0b",
						exp_r.overflow, results_if.overflow);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned r;
		clk = 1'b0;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.sample = '0;
		items_if.final_in = 1'b0;
		results_if.ready = 1'b0;
		held_count = 0;
		held_dropped = 1'b0;
		error_count = 0;
		accepted_items = 0;
		stall_cycles = 0;
		item_taken = 1'b0;

		// single value set at the top extreme
		add_item(32'sh7fff_ffff, 1'b1);
		// descending run past the store size, closing sample dropped
		add_item(32'sh7fff_ffff, 1'b0);
		for (int i = 0; i < 14; i++)
			add_item(100 - 10 * i, 1'b0);
		add_item(32'sh8000_0000, 1'b0);
		add_item(32'sh0000_0000, 1'b1);
		// equal values and the bottom extreme
		add_item(-1, 1'b0);
		add_item(32'sh8000_0000, 1'b0);
		add_item(-1, 1'b0);
		add_item(32'sh5555_aaaa, 1'b0);
		add_item(-1, 1'b1);

		while (pending_items.size() < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (r < 70)
				add_set($urandom_range(8, 1));
			else if (r < 85)
				add_set($urandom_range(16, 9));
			else if (r < 93)
				add_set(MAX_COUNT);
			else
				add_set($urandom_range(MAX_COUNT + 5, MAX_COUNT + 1));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || items_if.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/isort_pkg.sv
hw/rtl/isort_in_if.sv
hw/rtl/isort_out_if.sv
hw/rtl/isort_cell.sv
hw/rtl/insertion_sorter.sv
bench/insertion_sorter_tb.sv
